// ----- rtl/core/set_assoc_cache_miss_classifier_core_macros.svh -----
// assertion macros shared by the cache classifier core
`ifndef SET_ASSOC_CACHE_MISS_CLASSIFIER_CORE_MACROS_SVH
`define SET_ASSOC_CACHE_MISS_CLASSIFIER_CORE_MACROS_SVH

// implication checked on every clock edge outside reset
`define SACM_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication outside reset
`define SACM_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/core/sacm_pkg.sv -----
// ----------------------------------------------------------------------------
// sacm_pkg
// shared types and constants of the cache miss classifier
// ----------------------------------------------------------------------------
package sacm_pkg;
    localparam int ADDR_W = 31;
    localparam int CNT_W  = 32;
    localparam int SETC_W = 11;
    localparam int WAYS_W = 4;

    localparam logic [1:0] KIND_NONE       = 2'd0;
    localparam logic [1:0] KIND_COMPULSORY = 2'd1;
    localparam logic [1:0] KIND_CONFLICT   = 2'd2;
    localparam logic [1:0] KIND_CAPACITY   = 2'd3;

    localparam logic [0:0] REG_SET_COUNT = 1'd0;
    localparam logic [0:0] REG_WAYS      = 1'd1;

    localparam logic [15:0] LFSR_SEED = 16'hACE1;
    localparam logic [15:0] LFSR_MASK = 16'hB400;

    // divider request and reply
    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] rem;
    } div_rsp_t;
endpackage

// ----- rtl/core/sacm_divider.sv -----
// ----------------------------------------------------------------------------
// sacm_divider
// restoring remainder unit, one quotient bit per cycle
// ----------------------------------------------------------------------------
module sacm_divider (
    input  logic              aclk,
    input  logic              aresetn,
    input  sacm_pkg::div_req_t req,
    output sacm_pkg::div_rsp_t rsp
);
    import sacm_pkg::*;

    logic        busy_reg;
    logic [5:0]  cnt_reg;
    logic [31:0] num_reg;
    logic [31:0] den_reg;
    logic [31:0] rem_reg;
    logic        done_reg;
    logic [32:0] shifted;
    logic [32:0] diff;

    assign shifted = {rem_reg, num_reg[31]};
    assign diff    = shifted - {1'b0, den_reg};

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd32;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (req.start) begin
            num_reg <= req.dividend;
            den_reg <= req.divisor;
            rem_reg <= '0;
        end else if (busy_reg) begin
            num_reg <= {num_reg[30:0], 1'b0};
            rem_reg <= diff[32] ? shifted[31:0] : diff[31:0];
        end
    end

    assign rsp.done = done_reg;
    assign rsp.rem  = rem_reg;
endmodule

// ----- rtl/core/sacm_line_store.sv -----
// ----------------------------------------------------------------------------
// sacm_line_store
// set-wide line memory, one row of all ways per set, valid bits by sweep
// ----------------------------------------------------------------------------
module sacm_line_store #(
    parameter int SETS    = 1024,
    parameter int NWAYS   = 8,
    parameter int IDX_W   = 10
) (
    input  logic                                 aclk,
    input  logic                                 rd_en,
    input  logic [IDX_W-1:0]                     rd_idx,
    output logic [NWAYS-1:0][sacm_pkg::ADDR_W:0] rd_row,
    input  logic                                 wr_en,
    input  logic [IDX_W-1:0]                     wr_idx,
    input  logic [NWAYS-1:0][sacm_pkg::ADDR_W:0] wr_row
);
    import sacm_pkg::*;

    // each way holds valid bit on top of the address
    logic [NWAYS-1:0][ADDR_W:0] mem [SETS];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_idx] <= wr_row;
        end
        if (rd_en) begin
            rd_row <= mem[rd_idx];
        end
    end
endmodule

// ----- rtl/core/set_assoc_cache_miss_classifier_core.sv -----
// ----------------------------------------------------------------------------
// set_assoc_cache_miss_classifier_core
// set-associative cache model that classifies misses and keeps counters
// ----------------------------------------------------------------------------
// Each address beat passes through these states in order: an idle state that
// accepts the beat, a division state for the bit-serial remainder by the set
// count (the victim remainder by the ways runs alongside), a read state for
// the row read of the set memory, an evaluate state for compare and
// write-back, and an output state that presents the result and holds while
// m_ready is low; no new beat is accepted before the result is taken. After
// reset a clearing pass over all MAX_SETS rows clears the set memory's valid
// bits before any beat is accepted; configuration writes are taken throughout.
`include "set_assoc_cache_miss_classifier_core_macros.svh"
module set_assoc_cache_miss_classifier_core #(
    parameter int MAX_SETS = 1024,
    parameter int MAX_WAYS = 8
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [sacm_pkg::ADDR_W-1:0] s_address,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_hit,
    output logic [1:0]                  m_miss_kind,
    output logic [sacm_pkg::CNT_W-1:0]  m_hit_total,
    output logic [sacm_pkg::CNT_W-1:0]  m_miss_total,
    output logic [sacm_pkg::CNT_W-1:0]  m_compulsory_total,
    output logic [sacm_pkg::CNT_W-1:0]  m_conflict_total,
    output logic [sacm_pkg::CNT_W-1:0]  m_capacity_total,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [0:0]                  cfg_index,
    input  logic [31:0]                 cfg_data
);
    import sacm_pkg::*;

    localparam int IDX_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int WI_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int NW_W  = $clog2(MAX_WAYS + 1);
    localparam int SC_W  = $clog2(MAX_SETS + 1);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_READ  = 3'd3;
    localparam logic [2:0] ST_EVAL  = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    logic [2:0]        state_reg;
    logic [SETC_W-1:0] set_count_reg;
    logic [WAYS_W-1:0] ways_reg;
    logic [IDX_W-1:0]  clr_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [IDX_W-1:0]  set_reg;
    logic [SC_W-1:0]   sets_reg;
    logic [NW_W-1:0]   nw_reg;
    logic [15:0]       lfsr_reg;
    logic [CNT_W-1:0]  hit_cnt_reg, miss_cnt_reg, comp_cnt_reg, conf_cnt_reg, cap_cnt_reg;
    logic              hit_reg;
    logic [1:0]        kind_reg;
    logic [15:0]       vsrc_reg;
    logic [NW_W-1:0]   vmod_reg;
    logic [4:0]        vcnt_reg;

    div_req_t div_req;
    div_rsp_t div_rsp;

    logic [MAX_WAYS-1:0][ADDR_W:0] rd_row;
    logic [MAX_WAYS-1:0][ADDR_W:0] wr_row;
    logic                          wr_en;
    logic [IDX_W-1:0]              wr_idx;

    // clamped configuration
    logic [SC_W-1:0] sets_c;
    logic [NW_W-1:0] nw_c;
    always_comb begin
        if (set_count_reg == '0) begin
            sets_c = SC_W'(1);
        end else if (32'(set_count_reg) > 32'(MAX_SETS)) begin
            sets_c = SC_W'(MAX_SETS);
        end else begin
            sets_c = SC_W'(set_count_reg);
        end
        if (ways_reg == '0) begin
            nw_c = NW_W'(1);
        end else if (32'(ways_reg) > 32'(MAX_WAYS)) begin
            nw_c = NW_W'(MAX_WAYS);
        end else begin
            nw_c = NW_W'(ways_reg);
        end
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    assign div_req.start    = s_valid && s_ready;
    assign div_req.dividend = 32'(s_address);
    assign div_req.divisor  = 32'(sets_c);

    sacm_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    sacm_line_store #(
        .SETS  (MAX_SETS),
        .NWAYS (MAX_WAYS),
        .IDX_W (IDX_W)
    ) u_store (
        .aclk   (aclk),
        .rd_en  (state_reg == ST_READ),
        .rd_idx (set_reg),
        .rd_row (rd_row),
        .wr_en  (wr_en),
        .wr_idx (wr_idx),
        .wr_row (wr_row)
    );

    // one restoring step of the victim remainder by the ways in use
    logic [NW_W:0]   vshift;
    logic [NW_W-1:0] vstep;
    assign vshift = {vmod_reg, vsrc_reg[15]};
    assign vstep  = (vshift >= {1'b0, nw_reg}) ? NW_W'(vshift - {1'b0, nw_reg})
                                               : NW_W'(vshift);

    // lookup over the fetched row
    logic              found;
    logic              have_empty;
    logic [WI_W-1:0]   empty_way;
    logic [NW_W-1:0]   valid_cnt;
    logic [15:0]       lfsr_adv;
    logic [WI_W-1:0]   victim;
    logic [1:0]        kind;
    always_comb begin
        found      = 1'b0;
        have_empty = 1'b0;
        empty_way  = '0;
        valid_cnt  = '0;
        for (int w = 0; w < MAX_WAYS; w++) begin
            if (NW_W'(w) < nw_reg) begin
                if (rd_row[w][ADDR_W]) begin
                    valid_cnt = valid_cnt + NW_W'(1);
                    if (rd_row[w][ADDR_W-1:0] == addr_reg) begin
                        found = 1'b1;
                    end
                end else if (!have_empty) begin
                    have_empty = 1'b1;
                    empty_way  = WI_W'(w);
                end
            end
        end
        lfsr_adv = lfsr_reg[0] ? ((lfsr_reg >> 1) ^ LFSR_MASK) : (lfsr_reg >> 1);
        victim   = have_empty ? empty_way : WI_W'(vmod_reg);
        if (found) begin
            kind = KIND_NONE;
        end else if (valid_cnt == '0) begin
            kind = KIND_COMPULSORY;
        end else if (sets_reg > SC_W'(1)) begin
            kind = KIND_CONFLICT;
        end else if (valid_cnt == nw_reg) begin
            kind = KIND_CAPACITY;
        end else begin
            kind = KIND_COMPULSORY;
        end
    end

    // write port: clearing sweep or fill
    always_comb begin
        wr_row = rd_row;
        wr_idx = set_reg;
        wr_en  = 1'b0;
        if (state_reg == ST_CLEAR) begin
            wr_en  = 1'b1;
            wr_idx = clr_reg;
            wr_row = '0;
        end else if (state_reg == ST_EVAL && !found) begin
            wr_en          = 1'b1;
            wr_row[victim] = {1'b1, addr_reg};
        end
    end

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        return (c == '1) ? c : c + CNT_W'(1);
    endfunction

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            set_count_reg <= SETC_W'(1024);
            ways_reg      <= WAYS_W'(1);
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_SET_COUNT: set_count_reg <= cfg_data[SETC_W-1:0];
                REG_WAYS:      ways_reg      <= cfg_data[WAYS_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer and counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_reg      <= '0;
            lfsr_reg     <= LFSR_SEED;
            hit_cnt_reg  <= '0;
            miss_cnt_reg <= '0;
            comp_cnt_reg <= '0;
            conf_cnt_reg <= '0;
            cap_cnt_reg  <= '0;
        end else begin
            unique case (state_reg)
                ST_CLEAR: begin
                    clr_reg <= clr_reg + IDX_W'(1);
                    if (32'(clr_reg) == MAX_SETS - 1) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_valid) begin
                        addr_reg  <= s_address;
                        sets_reg  <= sets_c;
                        nw_reg    <= nw_c;
                        vsrc_reg  <= lfsr_adv;
                        vmod_reg  <= '0;
                        vcnt_reg  <= 5'd16;
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    // victim remainder, done well before the set remainder
                    if (vcnt_reg != 5'd0) begin
                        vmod_reg <= vstep;
                        vsrc_reg <= {vsrc_reg[14:0], 1'b0};
                        vcnt_reg <= vcnt_reg - 5'd1;
                    end
                    if (div_rsp.done) begin
                        set_reg   <= IDX_W'(div_rsp.rem);
                        state_reg <= ST_READ;
                    end
                end
                ST_READ: state_reg <= ST_EVAL;
                ST_EVAL: begin
                    hit_reg  <= found;
                    kind_reg <= kind;
                    if (found) begin
                        hit_cnt_reg <= sat_inc(hit_cnt_reg);
                    end else begin
                        miss_cnt_reg <= sat_inc(miss_cnt_reg);
                        if (kind == KIND_CONFLICT) begin
                            conf_cnt_reg <= sat_inc(conf_cnt_reg);
                        end else if (kind == KIND_CAPACITY) begin
                            cap_cnt_reg <= sat_inc(cap_cnt_reg);
                        end else begin
                            comp_cnt_reg <= sat_inc(comp_cnt_reg);
                        end
                        if (!have_empty) begin
                            lfsr_reg <= lfsr_adv;
                        end
                    end
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (m_ready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid            = (state_reg == ST_OUT);
    assign m_hit              = hit_reg;
    assign m_miss_kind        = kind_reg;
    assign m_hit_total        = hit_cnt_reg;
    assign m_miss_total       = miss_cnt_reg;
    assign m_compulsory_total = comp_cnt_reg;
    assign m_conflict_total   = conf_cnt_reg;
    assign m_capacity_total   = cap_cnt_reg;

    `SACM_ASSERT_IMP(a_hit_kind, aclk, aresetn, m_valid && m_hit, m_miss_kind == KIND_NONE)
    `SACM_ASSERT_IMP(a_no_in_busy, aclk, aresetn, m_valid, !s_ready)
    `SACM_ASSERT_NEXT(a_lfsr_nz, aclk, aresetn, 1'b1, lfsr_reg != 16'd0)
endmodule
